>>> sv/vis_pkg.sv
package vis_pkg;

  localparam int MAX_EXTENT = 32;
  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = 8;

  localparam int POS_W   = 14;
  localparam int ADDR_W  = 15;
  localparam int EXT_W   = $clog2(MAX_EXTENT) + 1;
  localparam int CRD_W   = $clog2(MAX_EXTENT);
  localparam int IP_W    = POS_W - FRAC_BITS;
  localparam int WGT_W   = 3 * FRAC_BITS + 4;
  localparam int DAT_W   = 34;
  localparam int ACC_W   = WGT_W + DAT_W;
  localparam int DEPTH   = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_CUBIC  = 1'b1;

  localparam logic FUNC_WRITE  = 1'b0;

  // linear: S-t and t; cubic: twice catmull-rom, scaled by S^3
  function automatic logic signed [WGT_W-1:0] weight(
    input logic                   mode,
    input logic [FRAC_BITS-1:0]   t,
    input logic [2*FRAC_BITS-1:0] t2,
    input logic [3*FRAC_BITS-1:0] t3,
    input logic [1:0]             k
  );
    logic signed [WGT_W-1:0] ts, t2s, t3s, one, w;
    ts  = $signed({{(WGT_W-FRAC_BITS){1'b0}}, t});
    t2s = $signed({{(WGT_W-2*FRAC_BITS){1'b0}}, t2});
    t3s = $signed({{(WGT_W-3*FRAC_BITS){1'b0}}, t3});
    one = $signed({{(WGT_W-1){1'b0}}, 1'b1});
    w   = '0;
    if (mode == MODE_LINEAR) begin
      w = k[0] ? ts : (one <<< FRAC_BITS) - ts;
    end else begin
      case (k)
        2'd0: w = -(ts <<< (2*FRAC_BITS)) + (t2s <<< (FRAC_BITS+1)) - t3s;
        2'd1: w = (t3s <<< 1) + t3s - (t2s <<< (FRAC_BITS+2)) - (t2s <<< FRAC_BITS)
                  + (one <<< (3*FRAC_BITS+1));
        2'd2: w = -((t3s <<< 1) + t3s) + (t2s <<< (FRAC_BITS+2)) + (ts <<< (2*FRAC_BITS));
        default: w = t3s - (t2s <<< FRAC_BITS);
      endcase
    end
    return w;
  endfunction

endpackage

>>> sv/vis_mem.sv
module vis_mem (
  input  logic                            clk,
  input  logic                            we,
  input  logic [vis_pkg::ADDR_W-1:0]      addr,
  input  logic [vis_pkg::VALUE_BITS-1:0]  wdata,
  output logic [vis_pkg::VALUE_BITS-1:0]  rdata
);

  logic [vis_pkg::VALUE_BITS-1:0] mem [vis_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/volume_interpolating_sampler.sv
// Single-channel voxel volume with a trilinear or tricubic (Catmull-Rom) sampler.
// A write item goes to the voxel memory as it is taken. A sample item runs a sequencer
// around one shared multiply-accumulate unit fed from the single-port voxel memory,
// which needs a read state and a multiply state per neighbour plus one state per y and
// x pass step; then the result is held in an output register while the next item is
// taken. The memory is not cleared.
module volume_interpolating_sampler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  func,
  input  logic [vis_pkg::ADDR_W-1:0]            voxel_address,
  input  logic [vis_pkg::VALUE_BITS-1:0]        voxel_value,
  input  logic [vis_pkg::POS_W-1:0]             pos_x,
  input  logic [vis_pkg::POS_W-1:0]             pos_y,
  input  logic [vis_pkg::POS_W-1:0]             pos_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [vis_pkg::VALUE_BITS-1:0]        sample_value,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int F   = vis_pkg::FRAC_BITS;
  localparam int AW  = vis_pkg::ACC_W;
  localparam int DW  = vis_pkg::DAT_W;
  localparam int WW  = vis_pkg::WGT_W;
  localparam int EW  = vis_pkg::EXT_W;
  localparam int CW  = vis_pkg::CRD_W;
  localparam int IW  = vis_pkg::IP_W;
  localparam int VB  = vis_pkg::VALUE_BITS;
  localparam int PW  = vis_pkg::POS_W;
  localparam int SW  = 2 * EW - 1;
  localparam int NW  = IW + 2;
  localparam logic signed [AW-1:0] ONE_A = {{(AW-1){1'b0}}, 1'b1};
  localparam logic [PW-1:0] HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_T2   = 8'b0000_0010,
    ST_T3   = 8'b0000_0100,
    ST_ADDR = 8'b0000_1000,
    ST_MACZ = 8'b0001_0000,
    ST_MACY = 8'b0010_0000,
    ST_MACX = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [EW-1:0] size_x, size_y, size_z;
  logic          interp_mode;
  logic [EW-1:0] ex, ey, ez;
  logic [SW-1:0] sxy;

  logic [IW-1:0]    ip [3];
  logic [F-1:0]     tf [3];
  logic [2*F-1:0]   t2 [3];
  logic [3*F-1:0]   t3 [3];
  logic [1:0]       ci, cj, ck;

  logic signed [AW-1:0] acc_z, acc_y, acc_x;
  logic [VB-1:0]        rd_data;

  logic                     cfg_we, in_acc, out_acc, mem_we;
  logic [vis_pkg::ADDR_W-1:0] mem_addr, nb_addr;
  logic [CW-1:0]            nx, ny, nz;
  logic [1:0]               axis, wk;
  logic signed [WW-1:0]     wsel;
  logic signed [DW-1:0]     dsel;
  logic signed [AW-1:0]     prod, zr, yr, fr;

  function automatic logic [EW-1:0] ext_of(input logic [EW-1:0] s);
    if (s == '0) return {{(EW-1){1'b0}}, 1'b1};
    if (s > EW'(vis_pkg::MAX_EXTENT)) return EW'(vis_pkg::MAX_EXTENT);
    return s;
  endfunction

  function automatic logic [CW-1:0] nb_coord(
    input logic [IW-1:0] p, input logic [1:0] c, input logic mode, input logic [EW-1:0] e
  );
    logic signed [NW-1:0] v;
    logic [EW-1:0]        emax;
    v    = $signed({2'b00, p}) + $signed({{(NW-2){1'b0}}, c})
           - ((mode == vis_pkg::MODE_CUBIC) ? NW'(1) : NW'(0));
    emax = e - EW'(1);
    if (v < 0) return '0;
    if (v > $signed({{(NW-EW){1'b0}}, emax})) return emax[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic last(input logic [1:0] c, input logic mode);
    return (mode == vis_pkg::MODE_CUBIC) ? (c == 2'd3) : (c == 2'd1);
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= EW'(vis_pkg::MAX_EXTENT);
      size_y      <= EW'(vis_pkg::MAX_EXTENT);
      size_z      <= EW'(vis_pkg::MAX_EXTENT);
      interp_mode <= vis_pkg::MODE_LINEAR;
    end else if (cfg_we) begin
      case (paddr[3:2])
        vis_pkg::REG_SIZE_X: size_x <= pwdata[EW-1:0];
        vis_pkg::REG_SIZE_Y: size_y <= pwdata[EW-1:0];
        vis_pkg::REG_SIZE_Z: size_z <= pwdata[EW-1:0];
        vis_pkg::REG_MODE:   interp_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vis_pkg::REG_SIZE_X: prdata = {{(32-EW){1'b0}}, size_x};
      vis_pkg::REG_SIZE_Y: prdata = {{(32-EW){1'b0}}, size_y};
      vis_pkg::REG_SIZE_Z: prdata = {{(32-EW){1'b0}}, size_z};
      vis_pkg::REG_MODE:   prdata = {31'b0, interp_mode};
      default:             prdata = '0;
    endcase
  end

  assign ex = ext_of(size_x);
  assign ey = ext_of(size_y);
  assign ez = ext_of(size_z);

  always_ff @(posedge clk) begin
    sxy <= SW'(ex * ey);
  end

  // handshakes
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_acc  = out_valid & ~out_stall;
  assign mem_we   = in_acc & (func == vis_pkg::FUNC_WRITE);

  // neighbour address
  assign nx = nb_coord(ip[0], ci, interp_mode, ex);
  assign ny = nb_coord(ip[1], cj, interp_mode, ey);
  assign nz = nb_coord(ip[2], ck, interp_mode, ez);
  assign nb_addr = vis_pkg::ADDR_W'({{(16-CW){1'b0}}, nx} + 16'(ny * ex) + 16'(nz * sxy));
  assign mem_addr = (state == ST_IDLE) ? voxel_address : nb_addr;

  vis_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (voxel_value),
    .rdata (rd_data)
  );

  // pass rounding
  always_comb begin
    if (interp_mode == vis_pkg::MODE_CUBIC) begin
      zr = (acc_z + (ONE_A <<< (2*F-1))) >>> (2*F);
      yr = (acc_y + (ONE_A <<< (3*F-1))) >>> (3*F);
      fr = (acc_x + (ONE_A <<< (4*F+2))) >>> (4*F+3);
    end else begin
      zr = acc_z;
      yr = acc_y;
      fr = (acc_x + (ONE_A <<< (3*F-1))) >>> (3*F);
    end
  end

  // shared multiply-accumulate unit
  always_comb begin
    case (state)
      ST_MACY: begin
        axis = 2'd1;
        wk   = cj;
        dsel = zr[DW-1:0];
      end
      ST_MACX: begin
        axis = 2'd0;
        wk   = ci;
        dsel = yr[DW-1:0];
      end
      default: begin
        axis = 2'd2;
        wk   = ck;
        dsel = $signed({{(DW-VB){1'b0}}, rd_data});
      end
    endcase
    wsel = vis_pkg::weight(interp_mode, tf[axis], t2[axis], t3[axis], wk);
    prod = wsel * dsel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && (!out_valid || out_stall == 1'b0)) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ci        <= '0;
      cj        <= '0;
      ck        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && func != vis_pkg::FUNC_WRITE) begin
            state <= ST_T2;
          end
        end
        ST_T2:   state <= ST_T3;
        ST_T3:   state <= ST_ADDR;
        ST_ADDR: state <= ST_MACZ;
        ST_MACZ: begin
          if (last(ck, interp_mode)) begin
            ck    <= '0;
            state <= ST_MACY;
          end else begin
            ck    <= ck + 2'd1;
            state <= ST_ADDR;
          end
        end
        ST_MACY: begin
          if (last(cj, interp_mode)) begin
            cj    <= '0;
            state <= ST_MACX;
          end else begin
            cj    <= cj + 2'd1;
            state <= ST_ADDR;
          end
        end
        ST_MACX: begin
          if (last(ci, interp_mode)) begin
            ci    <= '0;
            state <= ST_FIN;
          end else begin
            ci    <= ci + 2'd1;
            state <= ST_ADDR;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_stall == 1'b0) begin
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          ip[0] <= IW'(((pos_x > HALF) ? pos_x - HALF : '0) >> F);
          ip[1] <= IW'(((pos_y > HALF) ? pos_y - HALF : '0) >> F);
          ip[2] <= IW'(((pos_z > HALF) ? pos_z - HALF : '0) >> F);
          tf[0] <= F'((pos_x > HALF) ? pos_x - HALF : '0);
          tf[1] <= F'((pos_y > HALF) ? pos_y - HALF : '0);
          tf[2] <= F'((pos_z > HALF) ? pos_z - HALF : '0);
        end
      end
      ST_T2: begin
        for (int a = 0; a < 3; a++) t2[a] <= tf[a] * tf[a];
        acc_z <= '0;
        acc_y <= '0;
        acc_x <= '0;
      end
      ST_T3: begin
        for (int a = 0; a < 3; a++) t3[a] <= t2[a] * tf[a];
      end
      ST_MACZ: acc_z <= acc_z + prod;
      ST_MACY: begin
        acc_y <= acc_y + prod;
        acc_z <= '0;
      end
      ST_MACX: begin
        acc_x <= acc_x + prod;
        acc_y <= '0;
      end
      ST_FIN: begin
        if (!out_valid || out_stall == 1'b0) begin
          if (fr < 0) begin
            sample_value <= '0;
          end else if (fr > $signed({{(AW-VB){1'b0}}, {VB{1'b1}}})) begin
            sample_value <= '1;
          end else begin
            sample_value <= fr[VB-1:0];
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func != vis_pkg::FUNC_WRITE |=> state == ST_T2)
    else $error("sample transfer did not start the sequencer");

  a_fin_posts: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && !out_valid |=> out_valid && state == ST_IDLE)
    else $error("finished sample not posted");

  a_linear_bounds: assert property (@(posedge clk) disable iff (rst)
    interp_mode == vis_pkg::MODE_LINEAR && state != ST_IDLE |-> ci < 2'd2 && cj < 2'd2 && ck < 2'd2)
    else $error("linear neighbour counter out of range");
`endif

endmodule
